[hw/rtl/raster_draw_address_engine_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the raster draw address engine
// Shared property forms; each use names its own label and message.
// ----------------------------------------------------------------------------
`ifndef RASTER_DRAW_ADDRESS_ENGINE_TOP_ASSERT_SVH
`define RASTER_DRAW_ADDRESS_ENGINE_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define RDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rde_pkg.sv]
// ----------------------------------------------------------------------------
// rde_pkg
// Types and fixed constants shared by the draw engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

  localparam int ADDR_BITS       = 48;
  localparam int COLOR_BITS      = 32;
  localparam int PITCH_BITS      = 16;
  localparam int SCREEN_BITS     = 13;
  localparam int PORT_COORD_BITS = 12;
  localparam int OP_BITS         = 3;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_BITS       = 2;

  localparam logic [OP_BITS-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_BITS-1:0] OP_LINE    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_OUTLINE = 3'd2;
  localparam logic [OP_BITS-1:0] OP_RECT    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_FULL    = 3'd4;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_LINE,
    KIND_OUTLINE,
    KIND_RECT,
    KIND_FULL
  } cmd_kind_t;

  typedef enum logic [1:0] {
    REG_BASE,
    REG_PITCH,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LINE,
    ST_FILL
  } back_state_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    cmd_kind_t kind;
  } q_ctrl_t;

  // step divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

[hw/rtl/rde_front.sv]
// ----------------------------------------------------------------------------
// rde_front
// Accepts input transactions, decodes op, queues valid items for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_front #(
  parameter int CB = 12
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [rde_pkg::OP_BITS-1:0]          op,
  input  wire  [rde_pkg::PORT_COORD_BITS-1:0]  x_start,
  input  wire  [rde_pkg::PORT_COORD_BITS-1:0]  y_start,
  input  wire  [rde_pkg::PORT_COORD_BITS-1:0]  x_end_or_width,
  input  wire  [rde_pkg::PORT_COORD_BITS-1:0]  y_end_or_height,
  input  wire  [rde_pkg::COLOR_BITS-1:0]       color,
  output rde_pkg::q_ctrl_t                     q_ctrl,
  output logic [CB-1:0]                        q_xs,
  output logic [CB-1:0]                        q_ys,
  output logic [CB-1:0]                        q_xe,
  output logic [CB-1:0]                        q_ye,
  output logic [rde_pkg::COLOR_BITS-1:0]       q_color,
  input  wire                                  q_pop
);
  import rde_pkg::*;

  cmd_kind_t             kind_mem  [QUEUE_DEPTH];
  logic [CB-1:0]         xs_mem    [QUEUE_DEPTH];
  logic [CB-1:0]         ys_mem    [QUEUE_DEPTH];
  logic [CB-1:0]         xe_mem    [QUEUE_DEPTH];
  logic [CB-1:0]         ye_mem    [QUEUE_DEPTH];
  logic [COLOR_BITS-1:0] color_mem [QUEUE_DEPTH];

  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 full;
  logic                 known_op;
  logic                 push;
  logic                 do_pop;
  cmd_kind_t            in_kind;

  always_comb begin
    known_op = 1'b1;
    in_kind  = KIND_TICK;
    unique case (op)
      OP_TICK:    in_kind = KIND_TICK;
      OP_LINE:    in_kind = KIND_LINE;
      OP_OUTLINE: in_kind = KIND_OUTLINE;
      OP_RECT:    in_kind = KIND_RECT;
      OP_FULL:    in_kind = KIND_FULL;
      default:    known_op = 1'b0;  // unused codes are taken and dropped
    endcase
  end

  assign full     = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign in_stall = full;
  assign push     = in_valid && !full && known_op;
  assign do_pop   = q_pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop)      count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_mem[wr_ptr]  <= in_kind;
      xs_mem[wr_ptr]    <= CB'(x_start);
      ys_mem[wr_ptr]    <= CB'(y_start);
      xe_mem[wr_ptr]    <= CB'(x_end_or_width);
      ye_mem[wr_ptr]    <= CB'(y_end_or_height);
      color_mem[wr_ptr] <= color;
    end
  end

  assign q_ctrl.valid = (count != '0);
  assign q_ctrl.kind  = kind_mem[rd_ptr];
  assign q_xs         = xs_mem[rd_ptr];
  assign q_ys         = ys_mem[rd_ptr];
  assign q_xe         = xe_mem[rd_ptr];
  assign q_ye         = ye_mem[rd_ptr];
  assign q_color      = color_mem[rd_ptr];

endmodule

`default_nettype wire

[hw/rtl/rde_div.sv]
// ----------------------------------------------------------------------------
// rde_div
// Radix-2 fraction divider: both line increments, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_div #(
  parameter int CB = 12,
  parameter int FB = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire  [CB:0]           mag_x,
  input  wire  [CB:0]           mag_y,
  input  wire  [CB:0]           divisor,
  output rde_pkg::div_status_t  status,
  output logic [FB:0]           quo_x,
  output logic [FB:0]           quo_y
);
  import rde_pkg::*;

  localparam int XW = CB + 1;
  localparam int CW = $clog2(FB + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [XW-1:0] dvs;
  logic [XW:0]   rem_x, rem_y;
  logic [XW:0]   tx, ty, rx_next, ry_next;
  logic          bx, by;

  // magnitudes never exceed the divisor, so the integer part is 0 or 1
  always_comb begin
    tx      = {rem_x[XW-1:0], 1'b0};
    ty      = {rem_y[XW-1:0], 1'b0};
    bx      = (tx >= {1'b0, dvs});
    by      = (ty >= {1'b0, dvs});
    rx_next = bx ? (tx - {1'b0, dvs}) : tx;
    ry_next = by ? (ty - {1'b0, dvs}) : ty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(FB);
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs   <= divisor;
      quo_x <= (FB+1)'(mag_x == divisor);
      quo_y <= (FB+1)'(mag_y == divisor);
      rem_x <= (mag_x == divisor) ? '0 : {1'b0, mag_x};
      rem_y <= (mag_y == divisor) ? '0 : {1'b0, mag_y};
    end else if (busy && cnt != '0) begin
      quo_x <= {quo_x[FB-1:0], bx};
      quo_y <= {quo_y[FB-1:0], by};
      rem_x <= rx_next;
      rem_y <= ry_next;
    end
  end

  assign status.busy = busy;
  assign status.done = busy && (cnt == '0);

endmodule

`default_nettype wire

[hw/rtl/rde_back.sv]
// ----------------------------------------------------------------------------
// rde_back
// Drawing engine: line/outline stepping, fills, address generation, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_back #(
  parameter int CB = 12,
  parameter int FB = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_write,
  input  wire  [1:0]                      cfg_index,
  input  wire  [rde_pkg::ADDR_BITS-1:0]   cfg_data,
  input  rde_pkg::q_ctrl_t                q_ctrl,
  input  wire  [CB-1:0]                   q_xs,
  input  wire  [CB-1:0]                   q_ys,
  input  wire  [CB-1:0]                   q_xe,
  input  wire  [CB-1:0]                   q_ye,
  input  wire  [rde_pkg::COLOR_BITS-1:0]  q_color,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [rde_pkg::ADDR_BITS-1:0]   pixel_address,
  output logic [rde_pkg::COLOR_BITS-1:0]  pixel_value,
  output logic                            last_pixel
);
  import rde_pkg::*;
  `include "raster_draw_address_engine_top_assert.svh"

  localparam int XW  = CB + 1;                          // outline corner width
  localparam int PXW = (XW > SCREEN_BITS) ? XW : SCREEN_BITS;
  localparam int PW  = XW + FB + 1;                     // signed fixed point

  // configuration
  logic [ADDR_BITS-1:0]   base_address;
  logic [PITCH_BITS-1:0]  row_pitch;
  logic [SCREEN_BITS-1:0] screen_width;
  logic [SCREEN_BITS-1:0] screen_height;

  back_state_t state, state_next;

  logic                  is_outline;
  logic [1:0]            seg;
  logic signed [PW-1:0]  pos_x, pos_y, step_x, step_y;
  logic [XW-1:0]         steps_left;
  logic                  neg_x, neg_y;
  logic [CB-1:0]         rect_ox, rect_oy;
  logic [PXW-1:0]        rect_w, rect_h;
  logic [PXW-1:0]        col, row;
  logic [COLOR_BITS-1:0] held_color;

  // control
  logic emit, emit_last, setup_go, fill_go, out_free, fill_col_wrap, fill_row_wrap;

  // segment setup
  logic [CB-1:0] src_ox, src_oy, src_w, src_h;
  logic [1:0]    seg_sel;
  logic [XW-1:0] cx0, cx1, cy0, cy1, ex0, ex1, ey0, ey1;
  logic [XW:0]   dx, dy;
  logic [XW-1:0] ax, ay, steps;

  // pixel address
  logic [PXW-1:0]            px, py;
  logic [PXW+PITCH_BITS-1:0] row_offset;
  logic [ADDR_BITS-1:0]      addr;

  div_status_t div_st;
  logic [FB:0] quo_x, quo_y;

  rde_div #(.CB(CB), .FB(FB)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (setup_go),
    .mag_x   (ax),
    .mag_y   (ay),
    .divisor (steps),
    .status  (div_st),
    .quo_x   (quo_x),
    .quo_y   (quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= '0;
      row_pitch     <= '0;
      screen_width  <= '0;
      screen_height <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE:   base_address  <= cfg_data;
        REG_PITCH:  row_pitch     <= cfg_data[PITCH_BITS-1:0];
        REG_WIDTH:  screen_width  <= cfg_data[SCREEN_BITS-1:0];
        REG_HEIGHT: screen_height <= cfg_data[SCREEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // endpoints of the next line: a line command, or an outline segment
  always_comb begin
    src_ox  = (state == ST_IDLE) ? q_xs : rect_ox;
    src_oy  = (state == ST_IDLE) ? q_ys : rect_oy;
    src_w   = (state == ST_IDLE) ? q_xe : CB'(rect_w);
    src_h   = (state == ST_IDLE) ? q_ye : CB'(rect_h);
    seg_sel = (state == ST_IDLE) ? 2'd0 : seg + 2'd1;
    cx0     = XW'(src_ox);
    cy0     = XW'(src_oy);
    cx1     = XW'(src_ox) + XW'(src_w);
    cy1     = XW'(src_oy) + XW'(src_h);
    if (state == ST_IDLE && q_ctrl.kind == KIND_LINE) begin
      ex0 = XW'(q_xs);
      ey0 = XW'(q_ys);
      ex1 = XW'(q_xe);
      ey1 = XW'(q_ye);
    end else begin
      case (seg_sel)
        2'd0: begin ex0 = cx0; ey0 = cy0; ex1 = cx1; ey1 = cy0; end  // top
        2'd1: begin ex0 = cx0; ey0 = cy0; ex1 = cx0; ey1 = cy1; end  // left
        2'd2: begin ex0 = cx1; ey0 = cy0; ex1 = cx1; ey1 = cy1; end  // right
        default: begin ex0 = cx0; ey0 = cy1; ex1 = cx1; ey1 = cy1; end  // bottom
      endcase
    end
    dx    = {1'b0, ex1} - {1'b0, ex0};
    dy    = {1'b0, ey1} - {1'b0, ey0};
    ax    = dx[XW] ? XW'(-dx) : dx[XW-1:0];
    ay    = dy[XW] ? XW'(-dy) : dy[XW-1:0];
    steps = (ax > ay) ? ax : ay;
  end

  assign out_free      = !out_valid || !out_stall;
  assign fill_col_wrap = !(({1'b0, col} + 1'b1) < {1'b0, rect_w});
  assign fill_row_wrap = !(({1'b0, row} + 1'b1) < {1'b0, rect_h});

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    setup_go   = 1'b0;
    fill_go    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_ctrl.valid) begin
          q_pop = 1'b1;
          case (q_ctrl.kind)
            KIND_LINE, KIND_OUTLINE: begin
              setup_go   = 1'b1;
              state_next = ST_DIV;
            end
            KIND_RECT: begin
              if (q_xe != '0 && q_ye != '0) begin
                fill_go    = 1'b1;
                state_next = ST_FILL;
              end
            end
            KIND_FULL: begin
              if (screen_width != '0 && screen_height != '0) begin
                fill_go    = 1'b1;
                state_next = ST_FILL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_st.done) state_next = ST_LINE;
      end
      ST_LINE: begin
        if (q_ctrl.valid && q_ctrl.kind != KIND_TICK) begin
          q_pop = 1'b1;                       // command while busy: dropped
        end else if (q_ctrl.valid && out_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          if (steps_left == '0) begin
            if (is_outline && seg != 2'd3) begin
              setup_go   = 1'b1;
              state_next = ST_DIV;
            end else begin
              emit_last  = 1'b1;
              state_next = ST_IDLE;
            end
          end
        end
      end
      ST_FILL: begin
        if (q_ctrl.valid && q_ctrl.kind != KIND_TICK) begin
          q_pop = 1'b1;
        end else if (q_ctrl.valid && out_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          if (fill_col_wrap && fill_row_wrap) begin
            emit_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_ctrl.valid && q_ctrl.kind != KIND_TICK) begin
      held_color <= q_color;
    end
    if (setup_go) begin
      pos_x      <= (PW'(ex0) << FB) + (PW'(1) << (FB - 1));
      pos_y      <= (PW'(ey0) << FB) + (PW'(1) << (FB - 1));
      steps_left <= steps;
      neg_x      <= dx[XW];
      neg_y      <= dy[XW];
      if (state == ST_IDLE) begin
        is_outline <= (q_ctrl.kind == KIND_OUTLINE);
        seg        <= 2'd0;
        rect_ox    <= q_xs;
        rect_oy    <= q_ys;
        rect_w     <= PXW'(q_xe);
        rect_h     <= PXW'(q_ye);
      end else begin
        seg <= seg + 2'd1;
      end
    end
    if (fill_go) begin
      if (q_ctrl.kind == KIND_FULL) begin
        rect_ox <= '0;
        rect_oy <= '0;
        rect_w  <= PXW'(screen_width);
        rect_h  <= PXW'(screen_height);
      end else begin
        rect_ox <= q_xs;
        rect_oy <= q_ys;
        rect_w  <= PXW'(q_xe);
        rect_h  <= PXW'(q_ye);
      end
      col <= '0;
      row <= '0;
    end
    if (state == ST_DIV && div_st.done) begin
      if (steps_left == '0) begin
        step_x <= '0;
        step_y <= '0;
      end else begin
        step_x <= neg_x ? -PW'(quo_x) : PW'(quo_x);
        step_y <= neg_y ? -PW'(quo_y) : PW'(quo_y);
      end
    end
    if (emit && state == ST_LINE && steps_left != '0) begin
      steps_left <= steps_left - 1'b1;
      pos_x      <= pos_x + step_x;
      pos_y      <= pos_y + step_y;
    end
    if (emit && state == ST_FILL) begin
      if (!fill_col_wrap) begin
        col <= col + 1'b1;
      end else begin
        col <= '0;
        if (!fill_row_wrap) row <= row + 1'b1;
      end
    end
  end

  // pixel coordinates and byte address
  always_comb begin
    if (state == ST_FILL) begin
      px = PXW'(rect_ox) + col;
      py = PXW'(rect_oy) + row;
    end else begin
      px = PXW'(pos_x[FB +: XW]);
      py = PXW'(pos_y[FB +: XW]);
    end
    row_offset = py * row_pitch;
    addr = base_address + ADDR_BITS'(row_offset) + ADDR_BITS'({px, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (rst)           out_valid <= 1'b0;
    else if (out_free) out_valid <= emit;
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      pixel_address <= addr;
      pixel_value   <= held_color;
      last_pixel    <= emit_last;
    end
  end

  `RDE_ASSERT_NOW(a_div_idle_outside, state != ST_DIV, !div_st.busy, "divider busy outside setup")
  `RDE_ASSERT_NEXT(a_div_wait, state == ST_DIV && !div_st.done, state == ST_DIV, "left setup early")
  `RDE_ASSERT_NOW(a_no_pop_in_setup, state == ST_DIV, !q_pop, "queue popped during setup")
  `RDE_ASSERT_NEXT(a_emit_shows, emit, out_valid, "pixel write lost at output register")

endmodule

`default_nettype wire

[hw/rtl/raster_draw_address_engine_top.sv]
// ----------------------------------------------------------------------------
// raster_draw_address_engine_top
// 2D draw engine: line, rectangle outline and fills into framebuffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one item per transaction: a
//   command (line, outline, rectangle fill, full fill) or a tick. A command
//   only loads the engine; each following tick yields one pixel write on the
//   output channel (out_valid/out_stall). Commands arriving while a command
//   is still drawing are dropped; ticks while idle and unused op codes give
//   nothing.
//   A tick accepted on the input is held in the front queue until the
//   engine pops it, and its pixel write is loaded into the output register
//   at the edge that pops it. While drawing, and while the output register
//   is not stalled, one tick per cycle is turned into a pixel. Each line,
//   and each of the four outline segments, first passes through the step
//   divider (one quotient bit per cycle); ticks wait in the queue meanwhile.
//   Fills start without setup. A stalled output register holds its
//   transaction; the engine stops and the four-entry front queue fills
//   before in_stall is raised. Reset clears configuration, the queue and
//   the engine to idle. Configuration (cfg_write/cfg_index/cfg_data) must
//   be written only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_draw_address_engine_top #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // configuration write port
  input  wire                                  cfg_write,
  input  wire  [1:0]                           cfg_index,
  input  wire  [rde_pkg::ADDR_BITS-1:0]        cfg_data,
  // command / tick input
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [rde_pkg::OP_BITS-1:0]          op,
  input  wire  [rde_pkg::PORT_COORD_BITS-1:0]  x_start,
  input  wire  [rde_pkg::PORT_COORD_BITS-1:0]  y_start,
  input  wire  [rde_pkg::PORT_COORD_BITS-1:0]  x_end_or_width,
  input  wire  [rde_pkg::PORT_COORD_BITS-1:0]  y_end_or_height,
  input  wire  [rde_pkg::COLOR_BITS-1:0]       color,
  // pixel write output
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [rde_pkg::ADDR_BITS-1:0]        pixel_address,
  output logic [rde_pkg::COLOR_BITS-1:0]       pixel_value,
  output logic                                 last_pixel
);
  import rde_pkg::*;

  q_ctrl_t               q_ctrl;
  logic [COORD_BITS-1:0] q_xs, q_ys, q_xe, q_ye;
  logic [COLOR_BITS-1:0] q_color;
  logic                  q_pop;

  // front: decode and queue
  rde_front #(.CB(COORD_BITS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .x_start         (x_start),
    .y_start         (y_start),
    .x_end_or_width  (x_end_or_width),
    .y_end_or_height (y_end_or_height),
    .color           (color),
    .q_ctrl          (q_ctrl),
    .q_xs            (q_xs),
    .q_ys            (q_ys),
    .q_xe            (q_xe),
    .q_ye            (q_ye),
    .q_color         (q_color),
    .q_pop           (q_pop)
  );

  // back: stepping, address math, output register
  rde_back #(.CB(COORD_BITS), .FB(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_ctrl        (q_ctrl),
    .q_xs          (q_xs),
    .q_ys          (q_ys),
    .q_xe          (q_xe),
    .q_ye          (q_ye),
    .q_color       (q_color),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .last_pixel    (last_pixel)
  );

endmodule

`default_nettype wire

[verif/raster_draw_address_engine_top_tb.sv]
// ----------------------------------------------------------------------------
// raster_draw_address_engine_top_tb
// Self-checking bench for the draw engine: a cycle-free pixel predictor
// tracks every accepted command and tick, and each pixel write leaving the
// block is checked in order against it. Lines, outlines, fills, busy drops,
// unused op codes, address wrap and output backpressure are exercised.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_draw_address_engine_top_tb;
  import rde_pkg::*;

  localparam int FRAC       = 16;
  localparam int SETTLE     = 60;     // queue plus divider latency, with margin
  localparam int WDOG_LIMIT = 20000;  // idle cycles before the run is declared hung
  localparam int ITEM_GOAL  = 650;

  typedef enum int {M_IDLE, M_LINE, M_OUTLINE, M_FILL} mode_t;

  typedef struct {
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] value;
    logic                  last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [ADDR_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_BITS-1:0] op = '0;
  logic [PORT_COORD_BITS-1:0] x_start = '0, y_start = '0;
  logic [PORT_COORD_BITS-1:0] x_end_or_width = '0, y_end_or_height = '0;
  logic [COLOR_BITS-1:0] color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ADDR_BITS-1:0] pixel_address;
  logic [COLOR_BITS-1:0] pixel_value;
  logic last_pixel;

  always #1 clk = ~clk;

  raster_draw_address_engine_top dut (.*);

  // --------------------------------------------------------------------------
  // Pixel predictor state: configuration copy and drawing engine copy.
  // --------------------------------------------------------------------------
  logic [ADDR_BITS-1:0] fb_base;
  logic [15:0] fb_pitch;
  logic [12:0] scr_w, scr_h;

  mode_t  mode;
  int     seg;
  longint px_fix, py_fix, dx_fix, dy_fix;
  int     steps_rem;
  int     org_x, org_y, ext_w, ext_h, col_i, row_i;
  logic [COLOR_BITS-1:0] pen;

  pixel_t pending_pixels[$];

  int  fail_count = 0;
  int  pixels_seen = 0;
  int  items_sent = 0;     // transactions that loaded a command or made a pixel
  int  idle_cycles = 0;
  bit  long_hold_req = 0;
  bit  stall_enable = 1;

  function automatic logic [ADDR_BITS-1:0] fb_addr(int x, int y);
    logic [63:0] a;
    a = 64'(fb_base) + 64'(y) * 64'(fb_pitch) + 64'(x) * 64'd4;
    return a[ADDR_BITS-1:0];
  endfunction

  function automatic longint frac_step(longint d, int n);
    longint q;
    q = ((d < 0 ? -d : d) << FRAC) / n;
    return d < 0 ? -q : q;
  endfunction

  function automatic void start_line(int x1, int y1, int x2, int y2);
    longint ddx, ddy;
    int ax, ay, n;
    ddx = x2 - x1;
    ddy = y2 - y1;
    ax = int'(ddx < 0 ? -ddx : ddx);
    ay = int'(ddy < 0 ? -ddy : ddy);
    n = ax > ay ? ax : ay;
    px_fix = (longint'(x1) << FRAC) + (64'sd1 << (FRAC - 1));
    py_fix = (longint'(y1) << FRAC) + (64'sd1 << (FRAC - 1));
    dx_fix = n == 0 ? 0 : frac_step(ddx, n);
    dy_fix = n == 0 ? 0 : frac_step(ddy, n);
    steps_rem = n;
  endfunction

  function automatic void start_edge(int s);
    int x1, y1;
    x1 = org_x + ext_w;
    y1 = org_y + ext_h;
    case (s)
      0: start_line(org_x, org_y, x1, org_y);   // top
      1: start_line(org_x, org_y, org_x, y1);   // left
      2: start_line(x1, org_y, x1, y1);         // right
      default: start_line(org_x, y1, x1, y1);   // bottom
    endcase
  endfunction

  function automatic void start_area(int x, int y, int w, int h);
    if (w == 0 || h == 0) return;
    org_x = x; org_y = y; ext_w = w; ext_h = h;
    col_i = 0; row_i = 0;
    mode = M_FILL;
  endfunction

  // Applies one accepted transaction; returns 1 if it loaded or drew anything.
  function automatic bit draw_predict(logic [2:0] o, int xs, int ys, int xe, int ye,
                                      logic [31:0] c);
    int px, py;
    pixel_t p;
    if (o != OP_TICK) begin
      if (mode != M_IDLE || o > OP_FULL) return 0;
      pen = c;
      case (o)
        OP_LINE: begin
          start_line(xs, ys, xe, ye);
          mode = M_LINE;
        end
        OP_OUTLINE: begin
          org_x = xs; org_y = ys; ext_w = xe; ext_h = ye;
          seg = 0;
          start_edge(0);
          mode = M_OUTLINE;
        end
        OP_RECT: start_area(xs, ys, xe, ye);
        default: start_area(0, 0, scr_w, scr_h);
      endcase
      return 1;
    end
    if (mode == M_IDLE) return 0;
    p.last = 1'b0;
    if (mode == M_FILL) begin
      px = org_x + col_i;
      py = org_y + row_i;
      if (col_i + 1 < ext_w) col_i++;
      else begin
        col_i = 0;
        if (row_i + 1 < ext_h) row_i++;
        else begin
          p.last = 1'b1;
          mode = M_IDLE;
        end
      end
    end else begin
      px = int'((px_fix >> FRAC) & 64'hFFFF);
      py = int'((py_fix >> FRAC) & 64'hFFFF);
      if (steps_rem != 0) begin
        steps_rem--;
        px_fix += dx_fix;
        py_fix += dy_fix;
      end else if (mode == M_OUTLINE && seg < 3) begin
        seg++;
        start_edge(seg);
      end else begin
        p.last = 1'b1;
        mode = M_IDLE;
      end
    end
    p.addr = fb_addr(px, py);
    p.value = pen;
    pending_pixels.push_back(p);
    return 1;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transaction per call, random gap in front of it.
  // --------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_item(logic [2:0] o, logic [11:0] xs, logic [11:0] ys,
                           logic [11:0] xe, logic [11:0] ye, logic [31:0] c);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    op = o; x_start = xs; y_start = ys;
    x_end_or_width = xe; y_end_or_height = ye; color = c;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (draw_predict(o, xs, ys, xe, ye, c)) items_sent++;
  endtask

  task automatic tick();
    send_item(OP_TICK, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
              $urandom);
  endtask

  // Ticks until the predicted engine is idle, then lets the block settle.
  task automatic drain();
    while (mode != M_IDLE) tick();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_wr(cfg_reg_t r, logic [ADDR_BITS-1:0] d);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = r;
    cfg_data = d;
    @(negedge clk);
    cfg_write = 1'b0;
    case (r)
      REG_BASE:  fb_base = d;
      REG_PITCH: fb_pitch = d[15:0];
      REG_WIDTH: scr_w = d[12:0];
      default:   scr_h = d[12:0];
    endcase
  endtask

  task automatic set_surface(logic [47:0] b, logic [15:0] p, logic [12:0] w,
                             logic [12:0] h);
    cfg_wr(REG_BASE, b);
    cfg_wr(REG_PITCH, 48'(p));
    cfg_wr(REG_WIDTH, 48'(w));
    cfg_wr(REG_HEIGHT, 48'(h));
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall, with an optional long hold-off on request.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    int r;
    if (long_hold_req) begin
      out_stall <= 1'b1;
      repeat (400) @(negedge clk);
      long_hold_req = 0;
      out_stall <= 1'b0;
    end else if (!stall_enable) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) out_stall <= 1'b0;
      else if (r < 97) out_stall <= 1'b1;
      else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(5, 40)) @(negedge clk);
      end
    end
  end

  // Pixel write checker: in-order compare against the predictor.
  always @(posedge clk) begin
    pixel_t e;
    if (!rst && out_valid && !out_stall) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel write addr=%h value=%h", pixel_address, pixel_value);
        fail_count++;
      end else begin
        e = pending_pixels.pop_front();
        if (pixel_address !== e.addr) begin
          $error("pixel_address expected %h actual %h", e.addr, pixel_address);
          fail_count++;
        end
        if (pixel_value !== e.value) begin
          $error("pixel_value expected %h actual %h", e.value, pixel_value);
          fail_count++;
        end
        if (last_pixel !== e.last) begin
          $error("last_pixel expected %b actual %b", e.last, last_pixel);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired, %0d pixels still expected", pending_pixels.size());
      $display("raster_draw_address_engine_top regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_lines();
    set_surface(48'h1234_5678_9ABC, 16'd16384, 13'd5, 13'd3);
    tick();                                                  // idle tick
    send_item(3'd5, 12'd1, 12'd2, 12'd3, 12'd4, 32'h1);      // unused codes
    send_item(3'd6, 12'd1, 12'd2, 12'd3, 12'd4, 32'h2);
    send_item(3'd7, 12'd1, 12'd2, 12'd3, 12'd4, 32'h3);
    send_item(OP_LINE, 12'd7, 12'd9, 12'd7, 12'd9, 32'hFFFF_FFFF);  // one pixel
    drain();
    send_item(OP_LINE, 12'd4030, 12'd4000, 12'd4095, 12'd4095, 32'h0);
    drain();
    send_item(OP_LINE, 12'd100, 12'd4095, 12'd90, 12'd4035, 32'hA5A5_5A5A);
    tick();
    send_item(OP_RECT, 12'd1, 12'd1, 12'd2, 12'd2, 32'h5);    // dropped, busy
    drain();
    send_item(OP_LINE, 12'd4095, 12'd10, 12'd4040, 12'd17, 32'h5A5A_A5A5);
    drain();
  endtask

  task automatic test_outline();
    send_item(OP_OUTLINE, 12'd10, 12'd20, 12'd3, 12'd2, 32'hC0DE_0001);
    drain();
    send_item(OP_OUTLINE, 12'd5, 12'd5, 12'd0, 12'd0, 32'hC0DE_0002);
    drain();
    send_item(OP_OUTLINE, 12'd4095, 12'd4095, 12'd3, 12'd2, 32'hC0DE_0003);
    drain();
  endtask

  task automatic test_fills();
    send_item(OP_RECT, 12'd3, 12'd4, 12'd3, 12'd2, 32'hF111_0001);
    drain();
    send_item(OP_RECT, 12'd3, 12'd4, 12'd0, 12'd7, 32'hF111_0002);  // empty
    send_item(OP_RECT, 12'd3, 12'd4, 12'd7, 12'd0, 32'hF111_0003);  // empty
    send_item(OP_RECT, 12'd4095, 12'd4095, 12'd12, 12'd1, 32'hF111_0004);
    drain();
    send_item(OP_FULL, 12'd0, 12'd0, 12'd0, 12'd0, 32'hF111_0005);
    drain();
    // address wrap with max base and pitch
    set_surface(48'hFFFF_FFFF_FFFF, 16'hFFFF, 13'd20, 13'd2);
    send_item(OP_FULL, 12'd0, 12'd0, 12'd0, 12'd0, 32'hF111_0006);
    drain();
    send_item(OP_RECT, 12'd4000, 12'd4095, 12'd3, 12'd2, 32'hF111_0007);
    drain();
    set_surface(48'h0, 16'h0, 13'd0, 13'd4096);
    send_item(OP_FULL, 12'd0, 12'd0, 12'd0, 12'd0, 32'hF111_0008);  // empty
    send_item(OP_LINE, 12'd1, 12'd2, 12'd3, 12'd9, 32'hF111_0009);
    drain();
    set_surface(48'h0, 16'h4, 13'd4096, 13'd0);
    send_item(OP_FULL, 12'd0, 12'd0, 12'd0, 12'd0, 32'hF111_000A);  // empty
    drain();
  endtask

  // endpoint near c, clamped to the coordinate range
  function automatic logic [11:0] near(logic [11:0] c);
    int v;
    if ($urandom_range(0, 19) == 0) v = int'(c) + int'($urandom_range(0, 120)) - 60;
    else v = int'(c) + int'($urandom_range(0, 24)) - 12;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  function automatic logic [11:0] extent();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0) return 12'd60 - 12'($urandom_range(0, 3));
    if (r < 3) return 12'd0;
    return 12'($urandom_range(1, 6));
  endfunction

  task automatic random_command();
    logic [11:0] xs, ys, xe, ye;
    int r;
    xs = 12'($urandom);
    ys = 12'($urandom);
    r = $urandom_range(0, 99);
    if (r < 35) begin
      xe = near(xs); ye = near(ys);
      send_item(OP_LINE, xs, ys, xe, ye, $urandom);
    end else if (r < 50) begin
      xe = $urandom_range(0, 9) == 0 ? extent() : 12'($urandom_range(0, 5));
      ye = 12'($urandom_range(0, 5));
      send_item(OP_OUTLINE, xs, ys, xe, ye, $urandom);
    end else if (r < 75) begin
      xe = extent();
      ye = xe > 12'd50 ? 12'd1 : extent();
      send_item(OP_RECT, xs, ys, xe, ye, $urandom);
    end else if (r < 85) begin
      send_item(OP_FULL, xs, ys, 12'($urandom), 12'($urandom), $urandom);
    end else begin
      send_item(3'($urandom_range(5, 7)), xs, ys, 12'($urandom), 12'($urandom),
                $urandom);
      tick();
    end
    // tick the command out, with the odd dropped command or noise in between
    while (mode != M_IDLE) begin
      r = $urandom_range(0, 99);
      if (r < 6)
        send_item(3'($urandom_range(1, 7)), 12'($urandom), 12'($urandom),
                  12'($urandom), 12'($urandom), $urandom);
      else tick();
    end
  endtask

  task automatic test_random();
    int n;
    n = 0;
    while (items_sent < ITEM_GOAL) begin
      if (n % 12 == 0) begin
        drain();
        set_surface(48'({$urandom, $urandom}), 16'($urandom),
                    13'($urandom_range(0, 8)), 13'($urandom_range(0, 4)));
      end
      random_command();
      n++;
    end
    drain();
  endtask

  // Output held off for a long stretch while ticks keep coming: the front
  // queue fills and in_stall must rise.
  task automatic test_backpressure();
    stall_enable = 0;
    send_item(OP_RECT, 12'd50, 12'd60, 12'd8, 12'd4, 32'hB00B_0001);
    long_hold_req = 1;
    while (mode != M_IDLE) tick();
    drain();
    stall_enable = 1;
  endtask

  initial begin
    fb_base = '0; fb_pitch = '0; scr_w = '0; scr_h = '0;
    mode = M_IDLE; seg = 0; steps_rem = 0;
    px_fix = 0; py_fix = 0; dx_fix = 0; dy_fix = 0;
    org_x = 0; org_y = 0; ext_w = 0; ext_h = 0; col_i = 0; row_i = 0;
    pen = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_lines();
    test_outline();
    test_fills();
    test_backpressure();
    test_random();

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered lines, outlines, rectangle and full fills, dropped and unused");
    $display("commands, address wrap and stalls: %0d items, %0d pixel writes checked",
             items_sent, pixels_seen);
    if (fail_count == 0) $display("raster_draw_address_engine_top regression: pass");
    else $display("raster_draw_address_engine_top regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
